// ===== sv/bf_pkg.sv =====
// bf_pkg: shared constants, weight tables and control types of the 5x5 bilateral filter.
// Tables are built at elaboration by a fixed-point exp() series.
// No dependencies.
`default_nettype none
package bf_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W      = 8;
	localparam int WGT_W      = 16;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 13;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int ACC_W      = 29;
	localparam int WSUM_W     = 21;
	localparam int NCELL      = 25;
	localparam int SEL_W      = 5;
	localparam int LINE_W     = 4 * PIX_W;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 13'd480;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_WGT, ST_PROD, ST_ACC, ST_DSTART, ST_DIV, ST_HOLD
	} state_t;

	typedef struct packed {
		logic shift;
		logic calc;
		logic mult;
	} cell_ctl_t;

	typedef logic [8:0][WGT_W-1:0]   sw_tab_t;
	typedef logic [255:0][WGT_W-1:0] iw_tab_t;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] Q30_HALF = 64'd1 << 29;
	localparam logic [63:0] W_SCALE = (64'd1 << WGT_W) - 64'd1;

	function automatic logic [63:0] div_small(input logic [63:0] x, input int k);
		case (k)
			1: div_small = x;
			2: div_small = x / 64'd2;
			3: div_small = x / 64'd3;
			4: div_small = x / 64'd4;
			5: div_small = x / 64'd5;
			6: div_small = x / 64'd6;
			7: div_small = x / 64'd7;
			8: div_small = x / 64'd8;
			9: div_small = x / 64'd9;
			10: div_small = x / 64'd10;
			11: div_small = x / 64'd11;
			12: div_small = x / 64'd12;
			13: div_small = x / 64'd13;
			14: div_small = x / 64'd14;
			15: div_small = x / 64'd15;
			16: div_small = x / 64'd16;
			default: div_small = x;
		endcase
	endfunction

	// exp(-16*y) in Q30, y already scaled to Q30; weight result in Q0.16
	function automatic logic [WGT_W-1:0] exp_weight(input logic [63:0] y);
		logic [63:0] term;
		longint      sum;
		logic [63:0] r;
		logic [63:0] wt;
		term = Q30_ONE;
		sum  = longint'(Q30_ONE);
		for (int k = 1; k <= 16; k++) begin
			term = div_small((term * y) >> 30, k);
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		r = 64'(sum);
		for (int k = 0; k < 4; k++)
			r = (r * r + Q30_HALF) >> 30;
		wt = (r * W_SCALE + Q30_HALF) >> 30;
		exp_weight = wt[WGT_W-1:0];
	endfunction

	function automatic sw_tab_t build_sw();
		sw_tab_t t;
		for (int i = 0; i < 9; i++)
			t[i] = exp_weight((64'(i) << 30) / 64'd32);
		build_sw = t;
	endfunction

	function automatic iw_tab_t build_iw();
		iw_tab_t t;
		for (int i = 0; i < 256; i++)
			t[i] = exp_weight((64'(i * i) << 30) / 64'd80000);
		build_iw = t;
	endfunction

	localparam sw_tab_t SW_TAB = build_sw();
	localparam iw_tab_t IW_TAB = build_iw();
endpackage
`default_nettype wire

// ===== sv/bf_ram.sv =====
// bf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/bf_cell.sv =====
// bf_cell: one window position; holds a pixel, shifts it left, and computes
// its bilateral weight and weighted pixel. Depends on bf_pkg.
`default_nettype none
module bf_cell (
	input  wire logic                      clk,
	input  wire bf_pkg::cell_ctl_t         ctl,
	input  wire logic [bf_pkg::PIX_W-1:0]  shift_in,
	input  wire logic [bf_pkg::PIX_W-1:0]  centre,
	input  wire logic                      in_frame,
	input  wire logic [3:0]                sp_idx,
	output logic      [bf_pkg::PIX_W-1:0]  pix_q,
	output logic      [bf_pkg::WGT_W-1:0]  wgt_s1,
	output logic      [bf_pkg::ACC_W-1:0]  prod_s2
);
	import bf_pkg::*;

	logic [PIX_W-1:0]   diff;
	logic [2*WGT_W-1:0] wprod;

	always_comb begin
		diff  = (pix_q >= centre) ? pix_q - centre : centre - pix_q;
		wprod = SW_TAB[sp_idx] * IW_TAB[diff];
	end

	always_ff @(posedge clk) begin
		if (ctl.shift)
			pix_q <= shift_in;
		if (ctl.calc)
			wgt_s1 <= in_frame ? wprod[2*WGT_W-1:WGT_W] : '0;
		// zero weight forces a zero product, even for a never-loaded pixel
		if (ctl.mult)
			prod_s2 <= (wgt_s1 == '0) ? '0 : ACC_W'(wgt_s1 * pix_q);
	end
endmodule
`default_nettype wire

// ===== sv/bf_div.sv =====
// bf_div: serial restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on bf_pkg.
`default_nettype none
module bf_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bf_pkg::ACC_W-1:0]   num,
	input  wire logic [bf_pkg::WSUM_W-1:0]  den,
	output logic                            done,
	output logic      [bf_pkg::PIX_W-1:0]   quo
);
	import bf_pkg::*;

	logic [ACC_W-1:0]  rem_q;
	logic [WSUM_W-1:0] den_q;
	logic [PIX_W-1:0]  q_q;
	logic [2:0]        cnt_q;
	logic              busy_q;
	logic [ACC_W-1:0]  trial;

	assign trial = ACC_W'(den_q) << cnt_q;
	assign quo   = (den_q == '0) ? '0 : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd7;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q && rem_q >= trial) begin
			rem_q        <= rem_q - trial;
			q_q[cnt_q]   <= 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== sv/bilateral_5x5_filter.sv =====
// bilateral_5x5_filter: top level of the streaming 5x5 bilateral filter.
// Depends on bf_pkg, bf_ram, bf_cell, bf_div.
//
// Usage: pixels enter in raster order on the s_ channel (tdata = pixel,
// tuser = 1 for a flush tick). Results leave on the m_ channel, tlast set
// on the frame's last pixel. Results lag the input by 2*width+2 items;
// after the frame's last pixel, flush ticks push the remaining results out.
// frame_width / frame_height are written on the cfg_ channel, by the user
// only while idle (not enforced); a write restarts the frame counters.
// One item is handled at a time: an item that gives no result passes
// through the load step only, one that gives a result also through the
// weight and product stages of the 25-cell window, an accumulate over the
// cells and the serial divider. The output register lets the next item be
// taken while a result waits; a stalled receiver holds the block in its
// last step until the result register frees up. Reset clears the counters
// and registers to their defaults; no clearing pass over the line RAM.
`default_nettype none
module bilateral_5x5_filter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // pixel_in
	input  wire logic                          s_tuser,  // action
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [7:0]                    m_tdata,  // pixel_out
	output logic                               m_tlast,  // frame_last
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bf_pkg::FH_W-1:0]       cfg_data
);
	import bf_pkg::*;

	state_t state_q, state_n;
	cell_ctl_t ctl;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [FW_W-1:0]  w;
	logic [FH_W-1:0]  h;
	logic [COL_W-1:0] in_col_q, col_c, col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-2:0] out_row_q;
	logic [PIX_W-1:0] pix_q;
	logic             emit_q, last_q;
	logic             accept, drain, skip, emit_c, last_c;
	logic [FW_W-1:0]  col_n;
	logic [4:0]       row_ok, col_ok;
	logic [NCELL-1:0] mask_q, mask_c;
	logic [LINE_W-1:0] rdata, wdata;
	logic [4:0][PIX_W-1:0] colv;
	logic [PIX_W-1:0]  cpix [NCELL];
	logic [WGT_W-1:0]  cwgt [NCELL];
	logic [ACC_W-1:0]  cprod [NCELL];
	logic [SEL_W-1:0]  sel_q;
	logic [ACC_W-1:0]  acc_q;
	logic [WSUM_W-1:0] wsum_q;
	logic              div_done;
	logic [PIX_W-1:0]  div_quo;
	logic              out_free;

	assign w = (fw_q == '0) ? FW_W'(1) : ((fw_q > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_q);
	assign h = (fh_q == '0) ? FH_W'(1) : ((fh_q > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_q);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign drain     = (in_row_q >= h);
	assign skip      = !drain && s_tuser;
	assign col_c     = ({1'b0, in_col_q} >= w) ? '0 : in_col_q;
	assign col_n     = {1'b0, col_c} + FW_W'(1);
	assign out_free  = !m_tvalid || m_tready;

	always_comb begin
		if (w == FW_W'(1))
			emit_c = in_row_q >= ROW_W'(4);
		else if (w == FW_W'(2))
			emit_c = in_row_q >= ROW_W'(3);
		else
			emit_c = (in_row_q >= ROW_W'(3)) ||
				(in_row_q == ROW_W'(2) && col_c >= COL_W'(2));
		last_c = ({1'b0, out_row_q} == h - FH_W'(1)) && ({1'b0, out_col_q} == w - FW_W'(1));
	end

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			if (k < 2) begin
				row_ok[k] = {1'b0, out_row_q} >= ROW_W'(2 - k);
				col_ok[k] = {1'b0, out_col_q} >= FW_W'(2 - k);
			end else begin
				row_ok[k] = ({1'b0, out_row_q} + ROW_W'(k - 2)) < h;
				col_ok[k] = ({1'b0, out_col_q} + FW_W'(k - 2)) < w;
			end
		end
		for (int n = 0; n < NCELL; n++)
			mask_c[n] = row_ok[n / 5] && col_ok[n % 5];
	end

	// line RAM: one word per column, four previous rows packed, newest lowest
	assign colv[0] = rdata[31:24];
	assign colv[1] = rdata[23:16];
	assign colv[2] = rdata[15:8];
	assign colv[3] = rdata[7:0];
	assign colv[4] = pix_q;
	assign wdata   = {colv[1], colv[2], colv[3], pix_q};

	bf_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (state_q == ST_LOAD),
		.waddr (col_q),
		.wdata (wdata),
		.raddr (col_c),
		.rdata (rdata)
	);

	assign ctl.shift = (state_q == ST_LOAD);
	assign ctl.calc  = (state_q == ST_WGT);
	assign ctl.mult  = (state_q == ST_PROD);

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		localparam int KR = g / 5;
		localparam int KC = g % 5;
		localparam int SP = (KC - 2) * (KC - 2) + (KR - 2) * (KR - 2);
		logic [PIX_W-1:0] sin;
		if (KC == 4) begin : g_edge
			assign sin = colv[KR];
		end else begin : g_inner
			assign sin = cpix[g + 1];
		end
		bf_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.shift_in (sin),
			.centre   (cpix[12]),
			.in_frame (mask_q[g]),
			.sp_idx   (4'(SP)),
			.pix_q    (cpix[g]),
			.wgt_s1   (cwgt[g]),
			.prod_s2  (cprod[g])
		);
	end

	bf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DSTART),
		.num    (acc_q),
		.den    (wsum_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (accept && !skip) state_n = ST_LOAD;
			ST_LOAD:   state_n = emit_q ? ST_WGT : ST_IDLE;
			ST_WGT:    state_n = ST_PROD;
			ST_PROD:   state_n = ST_ACC;
			ST_ACC:    if (sel_q == SEL_W'(NCELL - 1)) state_n = ST_DSTART;
			ST_DSTART: state_n = ST_DIV;
			ST_DIV:    if (div_done) state_n = ST_HOLD;
			ST_HOLD:   if (out_free) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fw_q      <= FW_RESET;
			fh_q      <= FH_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			emit_q    <= 1'b0;
			sel_q     <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (state_q == ST_HOLD && out_free)
				m_tvalid <= 1'b1;
			if (cfg_valid) begin
				if (cfg_index == REG_FRAME_WIDTH)
					fw_q <= cfg_data[FW_W-1:0];
				else
					fh_q <= cfg_data;
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (accept && !skip) begin
				emit_q <= emit_c;
				if (col_n >= w) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= col_n[COL_W-1:0];
				end
				if (emit_c) begin
					if (last_c) begin
						in_col_q  <= '0;
						in_row_q  <= '0;
						out_col_q <= '0;
						out_row_q <= '0;
					end else if ({1'b0, out_col_q} + FW_W'(1) >= w) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 12'd1;
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
			if (state_q == ST_PROD)
				sel_q <= '0;
			else if (state_q == ST_ACC)
				sel_q <= sel_q + SEL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q  <= drain ? '0 : s_tdata;
			col_q  <= col_c;
			mask_q <= mask_c;
			last_q <= last_c;
		end
		if (state_q == ST_PROD) begin
			acc_q  <= '0;
			wsum_q <= '0;
		end else if (state_q == ST_ACC) begin
			acc_q  <= acc_q + cprod[sel_q];
			wsum_q <= wsum_q + WSUM_W'(cwgt[sel_q]);
		end
		if (state_q == ST_HOLD && out_free) begin
			m_tdata <= div_quo;
			m_tlast <= last_q;
		end
	end

	a_load_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> $past(accept))
		else $error("load step without an accepted item");
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> sel_q < SEL_W'(NCELL))
		else $error("accumulate index out of range");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide step");
endmodule
`default_nettype wire
